// ===== rtl/scs1_pkg.sv =====
// Package for the scan code set 1 decoder: state and result types, code
// constants, modifier update and the key code lookup.
// No dependencies.
package scs1_pkg;

    localparam logic [7:0] PREFIX_E0 = 8'hE0;
    localparam logic [7:0] PREFIX_E1 = 8'hE1;

    localparam logic [6:0] SC_LSHIFT  = 7'h2A;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_LCTRL   = 7'h1D;
    localparam logic [6:0] SC_LALT    = 7'h38;
    localparam logic [6:0] SC_CAPS    = 7'h3A;
    localparam logic [6:0] SC_NUMLOCK = 7'h45;

    localparam int MOD_LSHIFT  = 0;
    localparam int MOD_RSHIFT  = 1;
    localparam int MOD_LCTRL   = 2;
    localparam int MOD_LALT    = 3;
    localparam int MOD_CAPS    = 4;
    localparam int MOD_NUMLOCK = 5;

    localparam logic [1:0] LEN_SINGLE = 2'd1;
    localparam logic [1:0] LEN_E0     = 2'd2;
    localparam logic [1:0] LEN_E1     = 2'd3;

    localparam logic [7:0] RAW_E0_HI = 8'hE0;
    localparam logic [7:0] RAW_E1_HI = 8'hE1;

    typedef struct packed {
        logic [1:0] bytes_held;
        logic [1:0] seq_len;
        logic [7:0] held1;      // first byte after an E1 prefix
        logic [5:0] mods;
    } dec_state_t;

    typedef struct packed {
        logic [23:0] event_code;
        logic [5:0]  key_code;
        logic        key_down;
        logic [5:0]  modifiers;
    } dec_result_t;

    function automatic logic [5:0] key_lookup(input logic [6:0] low);
        logic [5:0] k;
        case (low)
            7'h1C: k = 6'd1;
            7'h01: k = 6'd2;
            7'h0E: k = 6'd3;
            7'h0F: k = 6'd4;
            7'h39: k = 6'd5;
            7'h1E: k = 6'd6;
            7'h30: k = 6'd7;
            7'h2E: k = 6'd8;
            7'h20: k = 6'd9;
            7'h12: k = 6'd10;
            7'h21: k = 6'd11;
            7'h22: k = 6'd12;
            7'h23: k = 6'd13;
            7'h17: k = 6'd14;
            7'h24: k = 6'd15;
            7'h25: k = 6'd16;
            7'h26: k = 6'd17;
            7'h32: k = 6'd18;
            7'h31: k = 6'd19;
            7'h18: k = 6'd20;
            7'h19: k = 6'd21;
            7'h10: k = 6'd22;
            7'h13: k = 6'd23;
            7'h1F: k = 6'd24;
            7'h14: k = 6'd25;
            7'h16: k = 6'd26;
            7'h2F: k = 6'd27;
            7'h11: k = 6'd28;
            7'h2D: k = 6'd29;
            7'h15: k = 6'd30;
            7'h2C: k = 6'd31;
            7'h0B: k = 6'd32;
            7'h02: k = 6'd33;
            7'h03: k = 6'd34;
            7'h04: k = 6'd35;
            7'h05: k = 6'd36;
            7'h06: k = 6'd37;
            7'h07: k = 6'd38;
            7'h08: k = 6'd39;
            7'h09: k = 6'd40;
            7'h0A: k = 6'd41;
            7'h33: k = 6'd42;
            7'h34: k = 6'd43;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    // Shift/ctrl/alt follow make and break; locks toggle on make only.
    function automatic logic [5:0] mod_update(input logic [5:0] mods,
                                              input logic [6:0] low,
                                              input logic       make);
        logic [5:0] m;
        m = mods;
        case (low)
            SC_LSHIFT:  m[MOD_LSHIFT] = make;
            SC_RSHIFT:  m[MOD_RSHIFT] = make;
            SC_LCTRL:   m[MOD_LCTRL]  = make;
            SC_LALT:    m[MOD_LALT]   = make;
            SC_CAPS:    m[MOD_CAPS]    = mods[MOD_CAPS] ^ make;
            SC_NUMLOCK: m[MOD_NUMLOCK] = mods[MOD_NUMLOCK] ^ make;
            default:    m = mods;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/scan_code_set1_decoder.sv =====
// Top level of the scan code set 1 decoder: input register, decode stage,
// sequence state and output register. Depends on scs1_pkg, scs1_decode.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+---------------------------------------------
//   input   | in_valid, in_ready  | scan_byte
//   output  | out_valid, out_ready| event_code, key_code, key_down, modifiers
//
// One byte per cycle sustained while the output is not stalled; an event's last
// byte is held in the input register, then the event in the output register.
// Prefix bytes and the middle byte of an E1 sequence produce no beat.
// Reset clears the sequence counters and modifiers; a stalled output holds
// its beat and the input register keeps taking bytes that produce none.
module scan_code_set1_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  scan_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] event_code,
    output logic [5:0]  key_code,
    output logic        key_down,
    output logic [5:0]  modifiers
);
    import scs1_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_state_t  dec_state;
    logic        dec_emit;
    dec_result_t dec_result;
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t out_reg;
    logic        stage_go;

    scs1_decode u_decode (
        .scan_byte  (in_byte_reg),
        .state      (state_reg),
        .state_next (dec_state),
        .emit       (dec_emit),
        .result     (dec_result)
    );

    // the stage moves unless it has an event and the output beat is stuck
    assign stage_go = in_valid_reg && (!dec_emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || stage_go;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
        state_next = stage_go ? dec_state : state_reg;
        out_valid_next = out_valid_reg;
        if (stage_go && dec_emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= scan_byte;
        if (stage_go && dec_emit)
            out_reg <= dec_result;
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_reg.event_code;
    assign key_code   = out_reg.key_code;
    assign key_down   = out_reg.key_down;
    assign modifiers  = out_reg.modifiers;

`ifndef SYNTHESIS
    a_held_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_held <= state_reg.seq_len)
        else $error("sequence byte count beyond sequence length");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !stage_go |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input register lost its byte");

    a_mods_only_on_go: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_go |=> $stable(state_reg.mods))
        else $error("modifiers changed without a decoded byte");

    a_prefixed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code[23:7] != 17'd0
        |-> key_code == 6'd0 && modifiers == 6'd0)
        else $error("prefixed event carries key code or modifiers");
`endif

endmodule

// ===== rtl/scs1_decode.sv =====
// Combinational decode of one scan byte against the sequence state:
// next state, event strobe and event fields.
// Depends on scs1_pkg.
module scs1_decode (
    input  logic [7:0]           scan_byte,
    input  scs1_pkg::dec_state_t state,
    output scs1_pkg::dec_state_t state_next,
    output logic                 emit,
    output scs1_pkg::dec_result_t result
);
    import scs1_pkg::*;

    logic       start;
    logic [6:0] low;
    logic       make;
    logic [5:0] mods_new;

    assign low      = scan_byte[6:0];
    assign make     = ~scan_byte[7];
    assign mods_new = mod_update(state.mods, low, make);

    // a byte opens a new sequence unless one is in progress
    assign start = (state.bytes_held == 2'd0) || (state.bytes_held >= state.seq_len);

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;
        result.key_down = make;
        if (start)
        begin
            if (scan_byte == PREFIX_E1)
            begin
                state_next.seq_len    = LEN_E1;
                state_next.bytes_held = 2'd1;
            end
            else if (scan_byte == PREFIX_E0)
            begin
                state_next.seq_len    = LEN_E0;
                state_next.bytes_held = 2'd1;
            end
            else
            begin
                state_next.seq_len    = LEN_SINGLE;
                state_next.bytes_held = 2'd0;
                state_next.mods       = mods_new;
                emit                  = 1'b1;
                result.event_code     = {17'd0, low};
                result.key_code       = key_lookup(low);
                result.modifiers      = mods_new;
            end
        end
        else if (state.seq_len == LEN_E1 && state.bytes_held == 2'd1)
        begin
            state_next.held1      = scan_byte;
            state_next.bytes_held = 2'd2;
        end
        else
        begin
            state_next.bytes_held = 2'd0;
            emit                  = 1'b1;
            if (state.seq_len == LEN_E1)
                result.event_code = {RAW_E1_HI, 1'b0, state.held1[6:0], 1'b0, low};
            else
                result.event_code = {8'd0, RAW_E0_HI, 1'b0, low};
        end
    end

endmodule

// ===== dv/scan_event_checker.sv =====
// Checker for the scan code set 1 decoder: watches both channels, predicts each
// key event from the accepted bytes and compares results field by field.
// Depends on scs1_pkg for the result type and the scan code constants.
module scan_event_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  scan_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [23:0] event_code,
    input  logic [5:0]  key_code,
    input  logic        key_down,
    input  logic [5:0]  modifiers,
    output int          fail_count,
    output int          events_owed
);

    // Scan code of key code 1..43, first entry in the top byte.
    localparam logic [8*43-1:0] KEY_SCANS = {
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39,
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
        8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C,
        8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
        8'h33, 8'h34
    };

    logic [1:0] seq_taken;
    logic [1:0] seq_len;
    logic [7:0] e1_first;
    logic [5:0] mod_state;
    scs1_pkg::dec_result_t events_due[$];

    initial fail_count = 0;

    function automatic logic [5:0] key_for_scan(input logic [6:0] low);
        logic [5:0] k;
        int i;
        k = 6'd0;
        for (i = 0; i < 43; i++)
            if (KEY_SCANS[8*(42-i) +: 8] == {1'b0, low})
                k = 6'(i + 1);
        return k;
    endfunction

    task automatic report_mismatch(input string field, input logic [23:0] got,
                                   input logic [23:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH %s: got %h want %h at %0t", field, got, want, $time);
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        scs1_pkg::dec_result_t ev;
        logic [6:0] low;
        logic make;
        low  = b[6:0];
        make = ~b[7];
        if (seq_taken == 2'd0 || seq_taken >= seq_len)
        begin
            if (b == scs1_pkg::PREFIX_E1)
            begin
                seq_len   = scs1_pkg::LEN_E1;
                seq_taken = 2'd1;
            end
            else if (b == scs1_pkg::PREFIX_E0)
            begin
                seq_len   = scs1_pkg::LEN_E0;
                seq_taken = 2'd1;
            end
            else
            begin
                seq_len   = scs1_pkg::LEN_SINGLE;
                seq_taken = 2'd0;
                // modifiers change before the event reports them
                case (low)
                    scs1_pkg::SC_LSHIFT: mod_state[scs1_pkg::MOD_LSHIFT] = make;
                    scs1_pkg::SC_RSHIFT: mod_state[scs1_pkg::MOD_RSHIFT] = make;
                    scs1_pkg::SC_LCTRL:  mod_state[scs1_pkg::MOD_LCTRL]  = make;
                    scs1_pkg::SC_LALT:   mod_state[scs1_pkg::MOD_LALT]   = make;
                    scs1_pkg::SC_CAPS:
                        if (make)
                            mod_state[scs1_pkg::MOD_CAPS] = ~mod_state[scs1_pkg::MOD_CAPS];
                    scs1_pkg::SC_NUMLOCK:
                        if (make)
                            mod_state[scs1_pkg::MOD_NUMLOCK] =
                                ~mod_state[scs1_pkg::MOD_NUMLOCK];
                    default: ;
                endcase
                ev.event_code = {17'd0, low};
                ev.key_code   = key_for_scan(low);
                ev.key_down   = make;
                ev.modifiers  = mod_state;
                events_due.push_back(ev);
            end
        end
        else if (seq_len == scs1_pkg::LEN_E1 && seq_taken == 2'd1)
        begin
            e1_first  = b;
            seq_taken = 2'd2;
        end
        else
        begin
            if (seq_len == scs1_pkg::LEN_E1)
                ev.event_code = {scs1_pkg::RAW_E1_HI, 1'b0, e1_first[6:0], 1'b0, low};
            else
                ev.event_code = {8'd0, scs1_pkg::RAW_E0_HI, 1'b0, low};
            ev.key_code  = 6'd0;
            ev.key_down  = make;
            ev.modifiers = 6'd0;
            seq_taken    = 2'd0;
            events_due.push_back(ev);
        end
    endtask

    task automatic check_event();
        scs1_pkg::dec_result_t want;
        if (events_due.size() == 0)
        begin
            report_mismatch("unexpected beat, event_code", event_code, 24'd0);
        end
        else
        begin
            want = events_due.pop_front();
            if (event_code !== want.event_code)
                report_mismatch("event_code", event_code, want.event_code);
            if (key_code !== want.key_code)
                report_mismatch("key_code", {18'd0, key_code}, {18'd0, want.key_code});
            if (key_down !== want.key_down)
                report_mismatch("key_down", {23'd0, key_down}, {23'd0, want.key_down});
            if (modifiers !== want.modifiers)
                report_mismatch("modifiers", {18'd0, modifiers}, {18'd0, want.modifiers});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_taken = 2'd0;
            seq_len   = 2'd0;
            mod_state = 6'd0;
            events_due.delete();
            events_owed = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_event();
            if (in_valid && in_ready)
                absorb_byte(scan_byte);
            events_owed = events_due.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the scan code set 1 decoder: clock, reset, byte stimulus
// with bursty input and stalling output, and the final verdict.
// Depends on scan_code_set1_decoder, scan_event_checker and scs1_pkg.
module tb;

    localparam int RANDOM_BYTES = 1650;
    localparam int OPENING_LEN  = 28;

    // Directed opening: field extremes, every modifier make, shift/ctrl/alt breaks,
    // the caps lock break, prefixed events, and prefix values taken as data bytes.
    localparam logic [8*OPENING_LEN-1:0] OPENING = {
        8'h7F, 8'h80, 8'hFF, 8'h00,
        8'h2A, 8'h36, 8'h1D, 8'h38, 8'h3A, 8'h45,
        8'h1E,
        8'hAA, 8'hB6, 8'h9D, 8'hB8, 8'hBA,
        8'hE0, 8'h1D, 8'hE0, 8'h9D,
        8'hE1, 8'h1D, 8'hC5,
        8'hE1, 8'hE0, 8'hE1,
        8'hE0, 8'hE0
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  scan_byte = 8'd0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [23:0] event_code;
    logic [5:0]  key_code;
    logic        key_down;
    logic [5:0]  modifiers;
    int          fail_count;
    int          events_owed;

    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          steady = 1'b0;
    int          ready_mode = 0;
    int          ready_left = 0;

    scan_code_set1_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .scan_byte  (scan_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .key_code   (key_code),
        .key_down   (key_down),
        .modifiers  (modifiers)
    );

    scan_event_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .scan_byte   (scan_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_code  (event_code),
        .key_code    (key_code),
        .key_down    (key_down),
        .modifiers   (modifiers),
        .fail_count  (fail_count),
        .events_owed (events_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("scan_code_set1_decoder verification failed");
        $finish;
    end

    // Output side stalls on its own pattern, changing mode now and then.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 200);
        end
        else
        begin
            ready_left--;
        end
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Drive one beat and hold it until taken; gaps only fall between bursts.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        scan_byte <= b;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 15);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_random_sequence();
        int kind;
        logic [6:0] low;
        logic brk;
        kind = $urandom_range(0, 99);
        brk  = ($urandom_range(0, 9) < 4);
        if (kind < 15)
        begin
            send_byte(scs1_pkg::PREFIX_E0);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 25)
        begin
            send_byte(scs1_pkg::PREFIX_E1);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 40)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (kind < 55)
            begin
                case ($urandom_range(0, 5))
                    0: low = scs1_pkg::SC_LSHIFT;
                    1: low = scs1_pkg::SC_RSHIFT;
                    2: low = scs1_pkg::SC_LCTRL;
                    3: low = scs1_pkg::SC_LALT;
                    4: low = scs1_pkg::SC_CAPS;
                    default: low = scs1_pkg::SC_NUMLOCK;
                endcase
            end
            else
            begin
                low = 7'($urandom_range(0, 7'h3F));
            end
            send_byte({brk, low});
        end
    endtask

    initial
    begin
        int i;
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < OPENING_LEN; i++)
            send_byte(OPENING[8*(OPENING_LEN-1-i) +: 8]);

        while (bytes_sent < OPENING_LEN + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 99) == 0)
                steady = ~steady;
            send_random_sequence();
        end
        in_valid <= 1'b0;

        waited = 0;
        while (events_owed != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);

        if (fail_count == 0 && events_owed == 0)
            $display("scan_code_set1_decoder verification clean");
        else
            $display("scan_code_set1_decoder verification failed");
        $finish;
    end

endmodule
